// ===== hw/rtl/rwd_pkg.sv =====
// Shared types, constants and byte classification helpers for the repeated word detector.
package rwd_pkg;

  // Width of the minimum word length register
  localparam int unsigned CFG_W = 6;
  // Minimum word length after reset
  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 6'd2;

  // ASCII letter bounds and the case folding offset
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // Input request: one byte of text
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_req_t;

  // Result request: where a repeated word starts and how long it is
  typedef struct packed {
    logic [15:0] word_start;
    logic [5:0]  word_length;
  } out_req_t;

  // Per-cycle control that every window cell sees
  typedef struct packed {
    logic shift;  // a kept word enters the window, all words move one cell on
    logic clear;  // end of text, the window empties
    logic step;   // a letter byte is appended to the current word
    logic done;   // the current word is over, compare flags restart
  } cell_ctl_t;

  // Letters are ASCII A-Z, a-z and every byte with the top bit set.
  function automatic logic is_letter(input logic [7:0] c);
    logic upper;
    logic lower;
    upper = (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z);
    lower = (c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z);
    return upper || lower || c[7];
  endfunction

  // Folds ASCII upper case to lower case, passes every other byte unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] res;
    res = c;
    if ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      res = c + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rwd_cell.sv =====
// One window cell: holds one kept word and compares it with the word being read.
module rwd_cell import rwd_pkg::*; #(
  parameter int MAX_WORD_BYTES = 32,
  parameter int LEN_W          = 6,
  parameter int IDX_W          = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cell_ctl_t                      ctl,
  input  logic [IDX_W-1:0]               rd_idx,
  input  logic [7:0]                     in_byte,
  input  logic [LEN_W-1:0]               cur_len,
  input  logic [MAX_WORD_BYTES-1:0][7:0] prev_bytes,
  input  logic [LEN_W-1:0]               prev_len,
  output logic [MAX_WORD_BYTES-1:0][7:0] my_bytes,
  output logic [LEN_W-1:0]               my_len,
  output logic                           hit
);

  logic [MAX_WORD_BYTES-1:0][7:0] bytes_r;
  logic [LEN_W-1:0]               len_r;
  logic                           run_r;
  logic                           run_nxt;
  logic                           run_now;
  logic                           byte_eq;

  // Compare the incoming byte with the kept byte at the same offset.
  assign byte_eq = (bytes_r[rd_idx] == in_byte);
  assign run_now = run_r && (!ctl.step || byte_eq);

  // A hit needs every byte so far equal and the same length; length zero is an empty slot.
  assign hit = run_now && (len_r == cur_len) && (len_r != '0);

  // The running match flag restarts with every new word.
  assign run_nxt = ctl.done ? 1'b1 : run_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b1;
    end else begin
      run_r <= run_nxt;
    end
  end

  // Word length: loaded from the neighbor on a shift, emptied at end of text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (ctl.clear) begin
      len_r <= '0;
    end else if (ctl.shift) begin
      len_r <= prev_len;
    end
  end

  // Word bytes only move with the length that qualifies them.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      bytes_r <= prev_bytes;
    end
  end

  assign my_bytes = bytes_r;
  assign my_len   = len_r;

endmodule

// ===== hw/rtl/rwd_window.sv =====
// Chain of window cells, newest word at the head, with the combined hit.
module rwd_window import rwd_pkg::*; #(
  parameter int WINDOW_WORDS   = 4,
  parameter int MAX_WORD_BYTES = 32,
  parameter int LEN_W          = 6,
  parameter int IDX_W          = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cell_ctl_t                      ctl,
  input  logic [IDX_W-1:0]               rd_idx,
  input  logic [7:0]                     in_byte,
  input  logic [LEN_W-1:0]               cur_len,
  input  logic [MAX_WORD_BYTES-1:0][7:0] new_bytes,
  input  logic [LEN_W-1:0]               new_len,
  output logic                           hit_any
);

  logic [WINDOW_WORDS-1:0][MAX_WORD_BYTES-1:0][7:0] link_bytes;
  logic [WINDOW_WORDS-1:0][LEN_W-1:0]               link_len;
  logic [WINDOW_WORDS-1:0]                          hits;

  // The head cell takes the word that just ended.
  assign link_bytes[0] = new_bytes;
  assign link_len[0]   = new_len;

  // Each cell passes its word to the next; the oldest word falls off the end.
  for (genvar k = 0; k < WINDOW_WORDS; k++) begin : g_cell
    if (k < WINDOW_WORDS - 1) begin : g_mid
      rwd_cell #(
        .MAX_WORD_BYTES(MAX_WORD_BYTES),
        .LEN_W         (LEN_W),
        .IDX_W         (IDX_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_idx    (rd_idx),
        .in_byte   (in_byte),
        .cur_len   (cur_len),
        .prev_bytes(link_bytes[k]),
        .prev_len  (link_len[k]),
        .my_bytes  (link_bytes[k+1]),
        .my_len    (link_len[k+1]),
        .hit       (hits[k])
      );
    end else begin : g_tail
      rwd_cell #(
        .MAX_WORD_BYTES(MAX_WORD_BYTES),
        .LEN_W         (LEN_W),
        .IDX_W         (IDX_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_idx    (rd_idx),
        .in_byte   (in_byte),
        .cur_len   (cur_len),
        .prev_bytes(link_bytes[k]),
        .prev_len  (link_len[k]),
        .my_bytes  (),
        .my_len    (),
        .hit       (hits[k])
      );
    end
  end

  // Any cell that matches makes the word a repeat.
  assign hit_any = |hits;

endmodule

// ===== hw/rtl/repeated_word_detector.sv =====
// Repeated word detector: takes one text byte per clock cycle and reports words that
// repeat one of the last WINDOW_WORDS kept words, case folded for ASCII A-Z. Bytes
// stream at one per cycle; that rate is set by the single-byte compare that each window
// cell makes against its kept word as each letter arrives. A word that ends on a byte is
// reported in the cycle after that byte is accepted, through a one-request result
// register. While that result waits on out_ready, in_ready is low and the byte stream
// stalls until the result is taken. Words longer than MAX_WORD_BYTES never match.
// Position and window return to their reset values after the byte flagged last_byte.
module repeated_word_detector import rwd_pkg::*; #(
  parameter int WINDOW_WORDS   = 4,
  parameter int MAX_WORD_BYTES = 32,
  parameter int POSITION_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_req_t         out_data
);

  localparam int LEN_W = $clog2(MAX_WORD_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_WORD_BYTES);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int PW    = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  logic [CFG_W-1:0]               min_len_r;
  logic [LEN_W-1:0]               cur_len_r;
  logic [LEN_W-1:0]               cur_len_nxt;
  logic                           overlong_r;
  logic                           overlong_nxt;
  logic [POSITION_BITS-1:0]       start_r;
  logic [POSITION_BITS-1:0]       start_nxt;
  logic [POSITION_BITS-1:0]       pos_r;
  logic [POSITION_BITS-1:0]       pos_nxt;
  logic [MAX_WORD_BYTES-1:0][7:0] word_r;
  logic [MAX_WORD_BYTES-1:0][7:0] word_after;

  logic                           accept;
  logic                           letter;
  logic [7:0]                     folded;
  logic                           store_byte;
  logic [IDX_W-1:0]               wr_idx;
  logic [LEN_W-1:0]               len_after;
  logic                           ovl_after;
  logic                           word_starts;
  logic [POSITION_BITS-1:0]       start_after;
  logic                           have_word;
  logic                           finish;
  logic                           long_enough;
  logic                           commit;
  logic                           found;
  logic                           hit_any;
  logic [LEN_W-1:0]               new_len;
  logic [PW-1:0]                  start_ext;
  logic [CMP_W-1:0]               len_ext;
  cell_ctl_t                      ctl;

  logic                           out_valid_r;
  out_req_t                       out_data_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // A byte is taken whenever the result register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Classify the byte and work out the current word after it.
  assign letter      = is_letter(in_data.text_byte);
  assign folded      = fold_case(in_data.text_byte);
  assign store_byte  = letter && (cur_len_r < LEN_W'(MAX_WORD_BYTES));
  assign wr_idx      = cur_len_r[IDX_W-1:0];
  assign len_after   = store_byte ? (cur_len_r + LEN_W'(1)) : cur_len_r;
  assign ovl_after   = overlong_r || (letter && !store_byte);
  assign word_starts = letter && (cur_len_r == '0) && !overlong_r;
  assign start_after = word_starts ? pos_r : start_r;

  // Word end and whether the word is long enough to check and keep.
  assign len_ext     = CMP_W'(len_after);
  assign have_word   = (len_after != '0) || ovl_after;
  assign finish      = (!letter || in_data.last_byte) && have_word;
  assign long_enough = ovl_after || (len_ext >= CMP_W'(min_len_r));
  assign commit      = accept && finish && long_enough;
  assign found       = commit && !ovl_after && hit_any;

  // Current word bytes including this one, as handed to the window head.
  always_comb begin
    word_after = word_r;
    if (store_byte) begin
      word_after[wr_idx] = folded;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      word_r <= word_after;
    end
  end

  // Overlong words enter the window as an empty slot that never matches.
  assign new_len = ovl_after ? '0 : len_after;

  // Window control for this cycle.
  always_comb begin
    ctl       = '0;
    ctl.shift = commit;
    ctl.clear = accept && in_data.last_byte;
    ctl.step  = accept && store_byte;
    ctl.done  = accept && (finish || !letter || in_data.last_byte);
  end

  rwd_window #(
    .WINDOW_WORDS  (WINDOW_WORDS),
    .MAX_WORD_BYTES(MAX_WORD_BYTES),
    .LEN_W         (LEN_W),
    .IDX_W         (IDX_W)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_idx   (wr_idx),
    .in_byte  (folded),
    .cur_len  (len_after),
    .new_bytes(word_after),
    .new_len  (new_len),
    .hit_any  (hit_any)
  );

  // Next value of word tracking and text position.
  always_comb begin
    cur_len_nxt  = cur_len_r;
    overlong_nxt = overlong_r;
    start_nxt    = start_r;
    pos_nxt      = pos_r;
    if (accept) begin
      pos_nxt   = pos_r + POSITION_BITS'(1);
      start_nxt = start_after;
      if (in_data.last_byte) begin
        cur_len_nxt  = '0;
        overlong_nxt = 1'b0;
        start_nxt    = '0;
        pos_nxt      = '0;
      end else if (!letter) begin
        cur_len_nxt  = '0;
        overlong_nxt = 1'b0;
      end else begin
        cur_len_nxt  = len_after;
        overlong_nxt = ovl_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r  <= '0;
      overlong_r <= 1'b0;
      start_r    <= '0;
      pos_r      <= '0;
    end else begin
      cur_len_r  <= cur_len_nxt;
      overlong_r <= overlong_nxt;
      start_r    <= start_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Result register: holds one request until the consumer takes it.
  assign start_ext = PW'(start_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (found) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (found) begin
      out_data_r.word_start  <= start_ext[15:0];
      out_data_r.word_length <= len_ext[5:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
